### sv/skit_pkg.sv
package skit_pkg;

    localparam int CAPACITY  = 128;
    localparam int KEY_BYTES = 8;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 64;
    localparam int LOC_W     = 31;
    localparam int ENT_W     = 8;
    localparam int ROW_W     = KEY_W + LOC_W;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_BYTES);

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_FIND      = 2'd2,
        OP_FIND_NEXT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_WRITE_NEW,
        S_NEXT_RD,
        S_NEXT_GET,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ROW_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

### sv/sorted_key_index_table_core.sv
// Sorted key index table.
// Input channel (i_valid / o_stall) carries one operation: insert, delete,
// find or find-next, with a key and, for insert, a record location. Output
// channel (o_valid / i_stall) returns one result per operation: status,
// found location and the entry count after the operation.
// The entries live in one single-port-read RAM with a registered read. Every
// operation but an insert into a full table scans the table from entry 0,
// with a read state and a compare state for each entry visited. The scan
// stops at the match (for insert, at the insertion point) or at the entry
// count when there is none; find-next then reads the entry after the match.
// Insert and delete move the shifting entries a place each, and insert then
// writes the new entry; delete lowers the entry count. One operation is in
// work at a time; the input is stalled until its result sits in the output
// register. A held result stays on the outputs while i_stall is high, and
// the block may already take the next transfer. i_rst_n (synchronous,
// active low) empties the table and selects ascending order. i_cfg_we
// writes the order bit; do it only while no operation is in work.
module sorted_key_index_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_key,
    input  logic [30:0] i_location,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [30:0] o_found_location,
    output logic [7:0]  o_entries
);

    localparam int IW = skit_pkg::IDX_W;
    localparam int CW = skit_pkg::CNT_W;

    skit_pkg::t_state r_state, n_state;
    skit_pkg::t_op    r_op, n_op;
    logic [skit_pkg::KEY_W-1:0] r_key, n_key;
    logic [skit_pkg::LOC_W-1:0] r_loc, n_loc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_mv, n_mv;
    logic [1:0] r_stat, n_stat;
    logic [skit_pkg::LOC_W-1:0] r_found, n_found;
    logic r_desc, n_desc;
    logic r_ov, n_ov;
    logic [1:0] r_ostat, n_ostat;
    logic [skit_pkg::LOC_W-1:0] r_ofound, n_ofound;
    logic [7:0] r_oent, n_oent;

    skit_pkg::t_ram_req ram_req;
    logic [skit_pkg::ROW_W-1:0] ram_rdata;
    logic [skit_pkg::KEY_W-1:0] rd_key;
    logic [skit_pkg::LOC_W-1:0] rd_loc;
    logic accept;
    logic precedes;
    logic [CW-1:0] src;

    skit_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[skit_pkg::ROW_W-1:skit_pkg::LOC_W];
    assign rd_loc   = ram_rdata[skit_pkg::LOC_W-1:0];
    assign accept   = i_valid && (r_state == skit_pkg::S_IDLE);
    assign precedes = r_desc ? (r_key > rd_key) : (r_key < rd_key);
    assign src      = (r_op == skit_pkg::OP_INSERT) ? (r_mv - CW'(1)) : (r_mv + CW'(1));

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_loc    = r_loc;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_mv     = r_mv;
        n_stat   = r_stat;
        n_found  = r_found;
        n_desc   = i_cfg_we ? i_cfg_data : r_desc;
        n_ov     = r_ov && i_stall;
        n_ostat  = r_ostat;
        n_ofound = r_ofound;
        n_oent   = r_oent;
        ram_req.we    = 1'b0;
        ram_req.waddr = r_mv[IW-1:0];
        ram_req.wdata = ram_rdata;
        ram_req.raddr = r_idx[IW-1:0];

        unique case (r_state)
            skit_pkg::S_IDLE: begin
                if (accept) begin
                    n_op    = skit_pkg::t_op'(i_op);
                    n_key   = i_key & skit_pkg::KEY_MASK;
                    n_loc   = i_location;
                    n_idx   = '0;
                    n_stat  = skit_pkg::STAT_DONE;
                    n_found = '0;
                    if (skit_pkg::t_op'(i_op) == skit_pkg::OP_INSERT
                            && r_cnt == CW'(skit_pkg::CAPACITY)) begin
                        n_stat  = skit_pkg::STAT_FULL;
                        n_state = skit_pkg::S_RESP;
                    end else begin
                        n_state = skit_pkg::S_SCAN_RD;
                    end
                end
            end
            skit_pkg::S_SCAN_RD: begin
                if (r_idx == r_cnt) begin
                    if (r_op == skit_pkg::OP_INSERT) begin
                        n_pos   = r_cnt;
                        n_mv    = r_cnt;
                        n_state = skit_pkg::S_MOVE_RD;
                    end else begin
                        n_stat  = skit_pkg::STAT_NOT_FOUND;
                        n_state = skit_pkg::S_RESP;
                    end
                end else begin
                    n_state = skit_pkg::S_SCAN_CMP;
                end
            end
            skit_pkg::S_SCAN_CMP: begin
                n_state = skit_pkg::S_SCAN_RD;
                n_idx   = r_idx + CW'(1);
                case (r_op)
                    skit_pkg::OP_INSERT: begin
                        if (precedes) begin
                            n_pos   = r_idx;
                            n_mv    = r_cnt;
                            n_state = skit_pkg::S_MOVE_RD;
                        end
                    end
                    skit_pkg::OP_DELETE: begin
                        if (rd_key == r_key) begin
                            n_mv    = r_idx;
                            n_state = skit_pkg::S_MOVE_RD;
                        end
                    end
                    skit_pkg::OP_FIND: begin
                        if (rd_key == r_key) begin
                            n_found = rd_loc;
                            n_state = skit_pkg::S_RESP;
                        end
                    end
                    default: begin
                        if (rd_key == r_key) begin
                            if (r_idx + CW'(1) >= r_cnt) begin
                                n_stat  = skit_pkg::STAT_NOT_FOUND;
                                n_state = skit_pkg::S_RESP;
                            end else begin
                                n_state = skit_pkg::S_NEXT_RD;
                            end
                        end
                    end
                endcase
            end
            skit_pkg::S_MOVE_RD: begin
                ram_req.raddr = src[IW-1:0];
                if (r_op == skit_pkg::OP_INSERT) begin
                    n_state = (r_mv == r_pos) ? skit_pkg::S_WRITE_NEW : skit_pkg::S_MOVE_WR;
                end else if (r_mv + CW'(1) >= r_cnt) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = skit_pkg::S_RESP;
                end else begin
                    n_state = skit_pkg::S_MOVE_WR;
                end
            end
            skit_pkg::S_MOVE_WR: begin
                // The row read last cycle moves one place toward the gap.
                ram_req.we = 1'b1;
                n_mv       = src;
                n_state    = skit_pkg::S_MOVE_RD;
            end
            skit_pkg::S_WRITE_NEW: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_pos[IW-1:0];
                ram_req.wdata = {r_key, r_loc};
                n_cnt         = r_cnt + CW'(1);
                n_state       = skit_pkg::S_RESP;
            end
            skit_pkg::S_NEXT_RD: begin
                n_state = skit_pkg::S_NEXT_GET;
            end
            skit_pkg::S_NEXT_GET: begin
                n_found = rd_loc;
                n_state = skit_pkg::S_RESP;
            end
            skit_pkg::S_RESP: begin
                if (!r_ov || !i_stall) begin
                    n_ov     = 1'b1;
                    n_ostat  = r_stat;
                    n_ofound = r_found;
                    n_oent   = 8'(r_cnt);
                    n_state  = skit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skit_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skit_pkg::S_IDLE;
            r_cnt   <= '0;
            r_desc  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_desc  <= n_desc;
            r_ov    <= n_ov;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_loc    <= n_loc;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_mv     <= n_mv;
        r_stat   <= n_stat;
        r_found  <= n_found;
        r_ostat  <= n_ostat;
        r_ofound <= n_ofound;
        r_oent   <= n_oent;
    end

    assign o_stall          = (r_state != skit_pkg::S_IDLE);
    assign o_valid          = r_ov;
    assign o_status         = r_ostat;
    assign o_found_location = r_ofound;
    assign o_entries        = r_oent;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(skit_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> (r_state == skit_pkg::S_MOVE_WR || r_state == skit_pkg::S_WRITE_NEW))
        else $error("table written outside a write state");

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skit_pkg::S_NEXT_RD |-> r_idx < r_cnt)
        else $error("find-next reads past the last entry");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skit_pkg::S_IDLE && !accept |=> $stable(r_cnt))
        else $error("entry count changed while idle");
`endif

endmodule

### sv/skit_ram.sv
module skit_ram (
    input  logic                       i_clk,
    input  skit_pkg::t_ram_req         i_req,
    output logic [skit_pkg::ROW_W-1:0] o_rdata
);

    logic [skit_pkg::ROW_W-1:0] r_mem [skit_pkg::CAPACITY];
    logic [skit_pkg::ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
